// ===== hw/rtl/md5_message_digest_unit_assert.svh =====
// Assertion macros for the digest unit; clocked on i_clk, off during reset.
`ifndef MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH

`define MD5U_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MD5U_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/md5u_pkg.sv =====
package md5u_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_md5u_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_md5u_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD,
        BLK_PAD_LEN,
        BLK_LEN
    } t_blk_kind;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned WORD_ADDR_W = $clog2(BLOCK_WORDS);

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LAST_PAD_POS = 6'd55;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;

    localparam logic [31:0] K_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] K_ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] res;
        unique case (rnd[5:4])
            2'd0: res = rnd[3:0];
            2'd1: res = 4'(rnd[3:0] * 4'd5 + 4'd1);
            2'd2: res = 4'(rnd[3:0] * 4'd3 + 4'd5);
            default: res = 4'(rnd[3:0] * 4'd7);
        endcase
        return res;
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] quarter,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] res;
        unique case (quarter)
            2'd0: res = (b & c) | (~b & d);
            2'd1: res = (b & d) | (c & ~d);
            2'd2: res = b ^ c ^ d;
            default: res = c ^ (b | ~d);
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

// ===== hw/rtl/md5_message_digest_unit.sv =====
// MD5 digest unit. Message bytes enter one byte per cycle on the input channel
// while it is ready, and are stored in a 16 x 32-bit block memory with a
// registered read port. The byte that completes a 64-byte block, and every
// end-of-message input, starts a compression: a load of the chaining value, the
// rounds through the single round unit (one round per cycle, fed from the block
// memory), and a fold of the result. The input is not ready meanwhile.
// At end of message the padding and bit length are applied as the memory is
// read; a further block, holding only the length, follows when the pad mark
// lands past byte 55. The digest then leaves as four 32-bit words, word 0 first,
// each word holding four digest bytes least significant first; the unit returns
// to the initial chaining value after the fourth word is taken. The block memory
// needs no clearing after reset.
module md5_message_digest_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  md5u_pkg::t_md5u_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output md5u_pkg::t_md5u_out  o_out_data
);

    `include "md5_message_digest_unit_assert.svh"

    md5u_pkg::t_state    r_state, n_state;
    md5u_pkg::t_blk_kind r_kind, n_kind;
    logic                r_eom, n_eom;
    logic [5:0]          r_fill, n_fill;
    logic [63:0]         r_bits, n_bits;
    logic [5:0]          r_rnd, n_rnd;
    logic [1:0]          r_widx, n_widx;
    logic [31:0]         r_cv [4];
    logic [31:0]         n_cv [4];
    logic [31:0]         r_a, r_b, r_c, r_d;
    logic [31:0]         n_a, n_b, n_c, n_d;

    logic [31:0] r_mem [md5u_pkg::BLOCK_WORDS];
    logic [31:0] r_rdata;
    logic [md5u_pkg::WORD_ADDR_W-1:0] r_rd_g;
    logic [md5u_pkg::WORD_ADDR_W-1:0] rd_addr;

    logic        in_acc;
    logic [5:0]  fill_nx;
    logic [31:0] w_word;
    logic [31:0] rnd_sum;
    logic [5:0]  pos;

    assign o_in_ready  = (r_state == md5u_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == md5u_pkg::ST_OUT);

    always_comb begin
        o_out_data.digest_word = r_cv[r_widx];
        o_out_data.word_index  = r_widx;
        o_out_data.last_word   = (r_widx == 2'd3);
    end

    always_comb begin
        rd_addr = (r_state == md5u_pkg::ST_ROUND) ? md5u_pkg::msg_index(r_rnd + 6'd1)
                                                  : md5u_pkg::msg_index(6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.byte_valid) begin
            r_mem[r_fill[5:2]][{r_fill[1:0], 3'b000} +: 8] <= i_in_data.data_byte;
        end
        r_rdata <= r_mem[rd_addr];
        r_rd_g  <= rd_addr;
    end

    // mask in pad mark, zeros and length on the fly
    always_comb begin
        w_word = r_rdata;
        pos    = 6'd0;
        for (int j = 0; j < 4; j++) begin
            pos = {r_rd_g, 2'(j)};
            if (r_kind == md5u_pkg::BLK_DATA) begin
                w_word[8*j +: 8] = r_rdata[8*j +: 8];
            end else if (r_kind != md5u_pkg::BLK_LEN && pos < r_fill) begin
                w_word[8*j +: 8] = r_rdata[8*j +: 8];
            end else if (r_kind != md5u_pkg::BLK_LEN && pos == r_fill) begin
                w_word[8*j +: 8] = md5u_pkg::PAD_MARK;
            end else begin
                w_word[8*j +: 8] = 8'h00;
            end
        end
        if (r_kind == md5u_pkg::BLK_PAD_LEN || r_kind == md5u_pkg::BLK_LEN) begin
            if (r_rd_g == md5u_pkg::LEN_LO_WORD) begin
                w_word = r_bits[31:0];
            end else if (r_rd_g == md5u_pkg::LEN_HI_WORD) begin
                w_word = r_bits[63:32];
            end
        end
    end

    assign rnd_sum = r_a + md5u_pkg::round_fn(r_rnd[5:4], r_b, r_c, r_d) + w_word
                   + md5u_pkg::K_ADD[r_rnd];

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_eom   = r_eom;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_rnd   = r_rnd;
        n_widx  = r_widx;
        n_cv    = r_cv;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        fill_nx = i_in_data.byte_valid ? r_fill + 6'd1 : r_fill;
        unique case (r_state)
            md5u_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_fill = fill_nx;
                    n_eom  = i_in_data.end_of_message;
                    if (i_in_data.byte_valid) begin
                        n_bits = r_bits + 64'd8;
                    end
                    if (i_in_data.byte_valid && r_fill == md5u_pkg::LAST_BYTE_POS) begin
                        n_kind  = md5u_pkg::BLK_DATA;
                        n_state = md5u_pkg::ST_LOAD;
                    end else if (i_in_data.end_of_message) begin
                        n_kind  = (fill_nx <= md5u_pkg::LAST_PAD_POS) ? md5u_pkg::BLK_PAD_LEN
                                                                      : md5u_pkg::BLK_PAD;
                        n_state = md5u_pkg::ST_LOAD;
                    end
                end
            end
            md5u_pkg::ST_LOAD: begin
                n_a     = r_cv[0];
                n_b     = r_cv[1];
                n_c     = r_cv[2];
                n_d     = r_cv[3];
                n_rnd   = 6'd0;
                n_state = md5u_pkg::ST_ROUND;
            end
            md5u_pkg::ST_ROUND: begin
                n_a   = r_d;
                n_d   = r_c;
                n_c   = r_b;
                n_b   = r_b + md5u_pkg::rotl32(rnd_sum,
                                               md5u_pkg::K_ROT[{r_rnd[5:4], r_rnd[1:0]}]);
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = md5u_pkg::ST_FOLD;
                end
            end
            md5u_pkg::ST_FOLD: begin
                n_cv[0] = r_cv[0] + r_a;
                n_cv[1] = r_cv[1] + r_b;
                n_cv[2] = r_cv[2] + r_c;
                n_cv[3] = r_cv[3] + r_d;
                unique case (r_kind)
                    md5u_pkg::BLK_DATA: begin
                        if (r_eom) begin
                            n_kind  = md5u_pkg::BLK_PAD_LEN;
                            n_state = md5u_pkg::ST_LOAD;
                        end else begin
                            n_state = md5u_pkg::ST_IDLE;
                        end
                    end
                    md5u_pkg::BLK_PAD: begin
                        n_kind  = md5u_pkg::BLK_LEN;
                        n_state = md5u_pkg::ST_LOAD;
                    end
                    default: begin
                        n_widx  = 2'd0;
                        n_state = md5u_pkg::ST_OUT;
                    end
                endcase
            end
            md5u_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        n_cv[0] = md5u_pkg::IV0;
                        n_cv[1] = md5u_pkg::IV1;
                        n_cv[2] = md5u_pkg::IV2;
                        n_cv[3] = md5u_pkg::IV3;
                        n_bits  = 64'd0;
                        n_fill  = 6'd0;
                        n_eom   = 1'b0;
                        n_state = md5u_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = md5u_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= md5u_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= md5u_pkg::BLK_DATA;
            r_eom   <= 1'b0;
            r_fill  <= 6'd0;
            r_bits  <= 64'd0;
            r_rnd   <= 6'd0;
            r_widx  <= 2'd0;
            r_cv[0] <= md5u_pkg::IV0;
            r_cv[1] <= md5u_pkg::IV1;
            r_cv[2] <= md5u_pkg::IV2;
            r_cv[3] <= md5u_pkg::IV3;
        end else begin
            r_kind <= n_kind;
            r_eom  <= n_eom;
            r_fill <= n_fill;
            r_bits <= n_bits;
            r_rnd  <= n_rnd;
            r_widx <= n_widx;
            r_cv   <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
    end

    `MD5U_CHECK_NEXT(a_round_end, r_state == md5u_pkg::ST_ROUND && r_rnd == 6'd63,
        r_state == md5u_pkg::ST_FOLD, "round sequence did not end in fold")
    `MD5U_CHECK_NEXT(a_len_block, r_state == md5u_pkg::ST_FOLD && r_kind == md5u_pkg::BLK_PAD,
        r_state == md5u_pkg::ST_LOAD && r_kind == md5u_pkg::BLK_LEN, "length block missed")
    `MD5U_CHECK_NEXT(a_block_start,
        in_acc && (i_in_data.end_of_message
                   || (i_in_data.byte_valid && r_fill == md5u_pkg::LAST_BYTE_POS)),
        r_state == md5u_pkg::ST_LOAD, "compression not started")
    `MD5U_CHECK_NEXT(a_restart, o_out_valid && i_out_ready && o_out_data.last_word,
        o_in_ready && r_fill == 6'd0 && r_bits == 64'd0 && r_cv[0] == md5u_pkg::IV0,
        "state not reinitialized after digest")
    `MD5U_CHECK_NOW(a_one_side, o_out_valid, !o_in_ready, "input open while digest pending")

endmodule
